FILE: sv/heightfield_normal_map_top_assert.svh
// Assertion macros shared by the RTL files.
`ifndef HEIGHTFIELD_NORMAL_MAP_TOP_ASSERT_SVH
`define HEIGHTFIELD_NORMAL_MAP_TOP_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HNM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HNM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/hnm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hnm_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] height_in;
  } hnm_in_t;

  typedef struct packed {
    logic [7:0] normal_red;
    logic [7:0] normal_green;
    logic [7:0] normal_blue;
    logic [7:0] alpha_out;
    logic       coord_error;
  } hnm_out_t;

  localparam logic OP_STORE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam int unsigned RegWidth  = 0;
  localparam int unsigned RegHeight = 1;
  localparam int unsigned RegScale  = 2;

  // S < 2^35, L < 2^18; quotient fits 8 bits
  localparam int unsigned SqW  = 36;
  localparam int unsigned LenW = 18;

  // divider command / status between top and divider
  typedef struct packed {
    logic            start;
    logic [LenW+8:0] num;   // 255*(L+d), < 2^27
    logic [LenW:0]   den;   // 2L
  } hnm_div_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] quot;
  } hnm_div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/hnm_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "heightfield_normal_map_top_assert.svh"
// Restoring divider, one quotient bit per cycle; quotient known < 256.
module hnm_div import hnm_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire hnm_div_req_t req_i,
  output hnm_div_rsp_t      rsp_o
);
  localparam int unsigned NumW = LenW + 9;

  logic [NumW-1:0] rem_q, rem_d;
  logic [LenW:0]   den_q, den_d;
  logic [7:0]      quot_q, quot_d;
  logic [3:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [NumW-1:0] trial;

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = NumW'(den_q) << cnt_q[2:0];
    if (req_i.start) begin
      rem_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 4'd7;
      busy_d = 1'b1;
      quot_d = '0;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        quot_d[cnt_q[2:0]] = 1'b1;
      end
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

  `HNM_ASSERT_NEXT(a_div_done, clk_i, rst_ni, busy_q && cnt_q == 4'd0 && !req_i.start,
    done_q && !busy_q, "divider did not finish")
  `HNM_ASSERT_IMPL(a_div_excl, clk_i, rst_ni, done_q, !busy_q, "done while busy")
  `HNM_ASSERT_IMPL(a_div_start, clk_i, rst_ni, req_i.start, !busy_q, "start while busy")
endmodule
`default_nettype wire

FILE: sv/heightfield_normal_map_top.sv
`timescale 1ns / 1ps
`default_nettype none
`include "heightfield_normal_map_top_assert.svh"
// Channel  | Direction | Handshake          | Payload
// in       | in        | in_valid/in_ready  | hnm_in_t (op, x_pos, y_pos, height_in)
// out      | out       | out_valid/out_ready| hnm_out_t (RGB, alpha, coord_error)
// cfg      | in        | APB psel/penable   | width, height, scale
// A store transfer completes on acceptance; an out-of-range compute goes straight to output.
// A compute transfer makes 5 reads of the single-port height memory, then runs an
// 18-step square root (one result bit per cycle) and three divides; most of the time
// goes to the serial square root and divider.
// A zero-length direction skips the divides.
// Reset clears control and config only; the height memory is never cleared.
// A finished result sits in the output register; the next item is taken once
// it has been transferred.
module heightfield_normal_map_top import hnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire hnm_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output hnm_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_SQ   = 10'b0000000100,
    S_SQX  = 10'b0000001000,
    S_ROOT = 10'b0000010000,
    S_DIVX = 10'b0000100000,
    S_DIVY = 10'b0001000000,
    S_DIVZ = 10'b0010000000,
    S_WAIT = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // config
  logic [8:0]  width_q, height_q;
  logic [15:0] scale_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      scale_q  <= 16'd16384;
    end else if (cfg_wr) begin
      unique case (32'(paddr[3:2]))
        RegWidth:  width_q  <= pwdata[8:0];
        RegHeight: height_q <= pwdata[8:0];
        RegScale:  scale_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (32'(paddr[3:2]))
      RegWidth:  prdata = {23'd0, width_q};
      RegHeight: prdata = {23'd0, height_q};
      RegScale:  prdata = {16'd0, scale_q};
      default:   prdata = '0;
    endcase
  end

  // effective size, clamped
  logic [12:0] w_eff, h_eff;
  assign w_eff = (13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(width_q);
  assign h_eff = (13'(height_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(height_q);

  // item registers
  logic [XW-1:0] x_q, lx_q, rx_q;
  logic [YW-1:0] y_q, uy_q, dy_q;
  logic          bad;
  logic [12:0]   xin, yin;
  assign xin = 13'(in_data_i.x_pos);
  assign yin = 13'(in_data_i.y_pos);
  assign bad = (xin >= w_eff) || (yin >= h_eff);

  // height memory, single port, registered read
  logic [7:0]    mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= in_data_i.height_in;
    else        mem_rd_q      <= mem[mem_addr];
  end

  function automatic logic [AW-1:0] addr_of(logic [XW-1:0] xa, logic [YW-1:0] ya);
    return AW'(ya) * AW'(MAX_WIDTH) + AW'(xa);
  endfunction

  // read sequencing: 0 C, 1 L, 2 R, 3 U, 4 D; read data is registered and arrives in the next cycle
  logic [2:0] rd_cnt_q, rd_cnt_d;
  logic [7:0] hc_q, hl_q, hr_q, hu_q, hd_q;

  always_comb begin
    unique case (rd_cnt_q)
      3'd0:    mem_addr = addr_of(x_q, y_q);
      3'd1:    mem_addr = addr_of(lx_q, y_q);
      3'd2:    mem_addr = addr_of(rx_q, y_q);
      3'd3:    mem_addr = addr_of(x_q, uy_q);
      default: mem_addr = addr_of(x_q, dy_q);
    endcase
    if (state_q == S_IDLE)
      mem_addr = addr_of(XW'(in_data_i.x_pos), YW'(in_data_i.y_pos));
  end

  logic in_xfer, out_xfer;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_xfer   = out_valid_o && out_ready_i;
  assign mem_we     = in_xfer && (in_data_i.op == OP_STORE) && !bad;

  // direction and length
  logic signed [17:0] dx_q, dy_q2;
  logic [16:0]        dz_q;
  logic [SqW-1:0]     sq_q;
  logic [SqW-1:0]     rem_q;
  logic [LenW-1:0]    root_q;
  logic [4:0]         sq_cnt_q;
  logic [SqW+1:0]     root_trial;
  logic [SqW-1:0]     rem_shift;

  // one-bit-per-cycle digit square root on sq_q
  assign rem_shift  = {rem_q[SqW-3:0], sq_q[SqW-1:SqW-2]};
  assign root_trial = {2'b00, rem_shift} - {(SqW-LenW-1)'(0), root_q, 2'b01};

  hnm_out_t     res_q;
  logic         out_v_q;
  hnm_div_req_t dreq;
  hnm_div_rsp_t drsp;

  hnm_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic signed [LenW+1:0] dsel;
  always_comb begin
    unique case (state_q)
      S_DIVX:  dsel = (LenW+2)'(dx_q);
      S_DIVY:  dsel = (LenW+2)'(dy_q2);
      default: dsel = (LenW+2)'($signed({1'b0, dz_q}));
    endcase
    dreq.start = (state_q == S_DIVX || state_q == S_DIVY || state_q == S_DIVZ)
                 && !drsp.busy && (root_q != '0);
    dreq.num   = (LenW+9)'(((LenW+2)'($signed({1'b0, root_q})) + dsel)) * (LenW+9)'(255);
    dreq.den   = {root_q, 1'b0};
  end

  logic [1:0] comp_q;

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    unique case (state_q)
      S_IDLE: if (in_xfer) begin
        if (in_data_i.op == OP_COMPUTE) state_d = bad ? S_OUT : S_RD;
        rd_cnt_d = 3'd1;
        if (in_data_i.op == OP_COMPUTE && bad) state_d = S_OUT;
      end
      S_RD:   if (rd_cnt_q == 3'd5) state_d = S_SQ;
              else rd_cnt_d = rd_cnt_q + 3'd1;
      S_SQ:   state_d = S_SQX;
      S_SQX:  state_d = S_ROOT;
      S_ROOT: if (sq_cnt_q == 5'd0) state_d = S_DIVX;
      S_DIVX: state_d = (root_q == '0) ? S_OUT : S_WAIT;
      S_DIVY: state_d = S_WAIT;
      S_DIVZ: state_d = S_WAIT;
      S_WAIT: if (drsp.done) begin
        unique case (comp_q)
          2'd0:    state_d = S_DIVY;
          2'd1:    state_d = S_DIVZ;
          default: state_d = S_OUT;
        endcase
      end
      S_OUT:  if (out_xfer) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // neighbor coordinates with torus wrap
  logic [XW-1:0] xi, wm1;
  logic [YW-1:0] yi, hm1;
  assign xi  = XW'(in_data_i.x_pos);
  assign yi  = YW'(in_data_i.y_pos);
  assign wm1 = XW'(w_eff - 13'd1);
  assign hm1 = YW'(h_eff - 13'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_cnt_q <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_cnt_q <= rd_cnt_d;
      if (out_xfer) out_v_q <= 1'b0;
      else if (state_q == S_OUT) out_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q  <= xi;
      y_q  <= yi;
      lx_q <= (xi == '0) ? wm1 : xi - XW'(1);
      rx_q <= (13'(xi) + 13'd1 >= w_eff) ? '0 : xi + XW'(1);
      uy_q <= (yi == '0) ? hm1 : yi - YW'(1);
      dy_q <= (13'(yi) + 13'd1 >= h_eff) ? '0 : yi + YW'(1);
      res_q <= {32'd0, bad};
    end
    if (state_q == S_IDLE && in_xfer) hc_q <= 8'd0;
    if (state_q == S_RD) begin
      unique case (rd_cnt_q)
        3'd1:    hc_q <= mem_rd_q;
        3'd2:    hl_q <= mem_rd_q;
        3'd3:    hr_q <= mem_rd_q;
        3'd4:    hu_q <= mem_rd_q;
        default: hd_q <= mem_rd_q;
      endcase
    end
    if (state_q == S_SQ) begin
      dx_q  <= 18'($signed({1'b0, hl_q}) - $signed({1'b0, hr_q})) <<< 8;
      dy_q2 <= 18'($signed({1'b0, hu_q}) - $signed({1'b0, hd_q})) <<< 8;
      dz_q  <= {scale_q, 1'b0};
      res_q.alpha_out <= hc_q;
    end
    if (state_q == S_SQX) begin
      sq_q <= SqW'(dx_q * dx_q) + SqW'(dy_q2 * dy_q2) + SqW'(dz_q * dz_q);
      rem_q    <= '0;
      root_q   <= '0;
      sq_cnt_q <= 5'(LenW - 1);
    end
    if (state_q == S_ROOT) begin
      sq_q     <= {sq_q[SqW-3:0], 2'b00};
      sq_cnt_q <= sq_cnt_q - 5'd1;
      if (!root_trial[SqW+1]) begin
        rem_q  <= root_trial[SqW-1:0];
        root_q <= {root_q[LenW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_shift;
        root_q <= {root_q[LenW-2:0], 1'b0};
      end
    end
    if (state_q == S_DIVX) begin
      comp_q <= 2'd0;
      if (root_q == '0) begin
        res_q.normal_red   <= 8'd127;
        res_q.normal_green <= 8'd127;
        res_q.normal_blue  <= 8'd255;
      end
    end
    if (state_q == S_WAIT && drsp.done) begin
      unique case (comp_q)
        2'd0:    res_q.normal_red   <= drsp.quot;
        2'd1:    res_q.normal_green <= drsp.quot;
        default: res_q.normal_blue  <= drsp.quot;
      endcase
      comp_q <= comp_q + 2'd1;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  `HNM_ASSERT_IMPL(a_idle_ready, clk_i, rst_ni, out_v_q, state_q == S_OUT,
    "result valid outside output state")
  `HNM_ASSERT_NEXT(a_out_clear, clk_i, rst_ni, out_xfer, !out_valid_o,
    "result valid after transfer")
  `HNM_ASSERT_IMPL(a_no_write_busy, clk_i, rst_ni, mem_we, state_q == S_IDLE,
    "memory write outside idle")
endmodule
`default_nettype wire

FILE: tb/sv/heightfield_normal_map_top_tb.sv
`timescale 1ns / 1ps
module heightfield_normal_map_top_tb;
  import hnm_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  hnm_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hnm_out_t    out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  heightfield_normal_map_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // shadow of the height image and the registers
  logic [7:0]  height_img [0:65535];
  logic [8:0]  img_w;
  logic [8:0]  img_h;
  logic [15:0] scale_q88;
  hnm_out_t    expected_px[$];
  int          errors = 0;
  bit          hold_out = 1'b0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] to_color(longint d, longint len);
    return 8'((255 * (len + d)) / (2 * len));
  endfunction

  // updates the image shadow; returns 1 when a pixel comes back
  function automatic bit predict_pixel(hnm_in_t it, output hnm_out_t px);
    int w, hh, lx, rx, uy, dy;
    longint gx, gy, gz, len;
    w = (img_w > 256) ? 256 : img_w;
    hh = (img_h > 256) ? 256 : img_h;
    px = '0;
    if (it.x_pos >= w || it.y_pos >= hh) begin
      if (it.op == OP_STORE) return 1'b0;
      px.coord_error = 1'b1;
      return 1'b1;
    end
    if (it.op == OP_STORE) begin
      height_img[{it.y_pos, it.x_pos}] = it.height_in;
      return 1'b0;
    end
    rx = (it.x_pos + 1 >= w) ? 0 : it.x_pos + 1;
    lx = (it.x_pos == 0) ? w - 1 : it.x_pos - 1;
    dy = (it.y_pos + 1 >= hh) ? 0 : it.y_pos + 1;
    uy = (it.y_pos == 0) ? hh - 1 : it.y_pos - 1;
    gx = (longint'(height_img[it.y_pos * 256 + lx]) -
          longint'(height_img[it.y_pos * 256 + rx])) * 256;
    gy = (longint'(height_img[uy * 256 + it.x_pos]) -
          longint'(height_img[dy * 256 + it.x_pos])) * 256;
    gz = longint'(scale_q88) * 2;
    len = longint'(root64(64'(gx * gx + gy * gy + gz * gz)));
    if (len == 0) begin
      px.normal_red = 8'd127;
      px.normal_green = 8'd127;
      px.normal_blue = 8'd255;
    end else begin
      px.normal_red = to_color(gx, len);
      px.normal_green = to_color(gy, len);
      px.normal_blue = to_color(gz, len);
    end
    px.alpha_out = height_img[{it.y_pos, it.x_pos}];
    return 1'b1;
  endfunction

  task automatic reg_write(int unsigned idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 4'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      RegWidth:  img_w = val[8:0];
      RegHeight: img_h = val[8:0];
      default:   scale_q88 = val[15:0];
    endcase
  endtask

  task automatic send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 80)) @(negedge clk);
  endtask

  task automatic send_item(hnm_in_t it);
    hnm_out_t px;
    send_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_pixel(it, px)) expected_px.push_back(px);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_px.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic config_all(int unsigned w, int unsigned h, int unsigned s);
    drain();
    reg_write(RegWidth, w);
    reg_write(RegHeight, h);
    reg_write(RegScale, s);
  endtask

  function automatic hnm_in_t mk(logic op, int x, int y, int h);
    hnm_in_t it;
    it.op = op; it.x_pos = 8'(x); it.y_pos = 8'(y); it.height_in = 8'(h);
    return it;
  endfunction

  // fill the whole w x h image so every compute reads written pixels
  task automatic fill_image(int w, int h, bit ramp);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send_item(mk(OP_STORE, x, y, ramp ? ((x * 37 + y * 91) & 255) : $urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    config_all(4, 3, 256);
    send_item(mk(OP_STORE, 0, 0, 0));
    send_item(mk(OP_STORE, 1, 0, 255));
    send_item(mk(OP_STORE, 2, 0, 0));
    send_item(mk(OP_STORE, 3, 0, 255));
    for (int x = 0; x < 4; x++) send_item(mk(OP_STORE, x, 1, (x & 1) ? 0 : 255));
    for (int x = 0; x < 4; x++) send_item(mk(OP_STORE, x, 2, 128));
    send_item(mk(OP_COMPUTE, 0, 0, 0));   // left edge wraps
    send_item(mk(OP_COMPUTE, 3, 2, 255)); // right and bottom edges wrap
    send_item(mk(OP_COMPUTE, 1, 1, 0));
    send_item(mk(OP_STORE, 4, 0, 9));     // out of range write is dropped
    send_item(mk(OP_COMPUTE, 255, 255, 0));
    send_item(mk(OP_COMPUTE, 0, 3, 0));
    config_all(4, 3, 0);                  // zero scale
    send_item(mk(OP_COMPUTE, 1, 2, 0));
    send_item(mk(OP_STORE, 1, 0, 128));   // level neighbors around (1,1)
    send_item(mk(OP_COMPUTE, 1, 1, 0));   // zero length gives the flat normal
    config_all(0, 0, 65535);              // zero size: all out of range
    send_item(mk(OP_COMPUTE, 0, 0, 0));
    send_item(mk(OP_STORE, 0, 0, 1));
    config_all(4, 511, 1);                // height beyond limit clamps to 256
    send_item(mk(OP_COMPUTE, 2, 1, 0));
  endtask

  task automatic random_phase(int w, int h, int s, int n, bit ramp);
    int x, y;
    config_all(w, h, s);
    fill_image(w, h, ramp);
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
      if ($urandom_range(0, 9) < 8) begin
        x = x % w;
        y = y % h;
      end
      if ($urandom_range(0, 2) == 0)
        send_item(mk(OP_STORE, x, y, $urandom_range(0, 255)));
      else
        send_item(mk(OP_COMPUTE, x, y, $urandom_range(0, 255)));
    end
  endtask

  task automatic test_random();
    random_phase(8, 8, $urandom_range(1, 65535), 80, 1'b0);
    random_phase(2, 2, 1, 50, 1'b0);
    random_phase(16, 5, 65535, 80, 1'b0);
    random_phase(3, 16, 0, 80, 1'b0);
    random_phase(12, 10, $urandom_range(1, 1024), 60, 1'b0);
  endtask

  // the wide and the tall image together touch every bit of both coordinates
  task automatic test_full_rows();
    config_all(256, 1, 16384);
    fill_image(256, 1, 1'b1);
    for (int i = 0; i < 30; i++)
      send_item(mk(OP_COMPUTE, $urandom_range(0, 255), 0, 0));
    config_all(1, 256, 300);
    fill_image(1, 256, 1'b1);
    for (int i = 0; i < 30; i++)
      send_item(mk(OP_COMPUTE, 0, $urandom_range(0, 255), 0));
  endtask

  task automatic test_backpressure();
    config_all(4, 4, 512);
    fill_image(4, 4, 1'b0);
    hold_out = 1'b1;
    for (int i = 0; i < 6; i++) send_item(mk(OP_COMPUTE, i % 4, i / 4, 0));
    drain();
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    int r;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) out_ready <= 1'b1;
      else if (r < 97) out_ready <= 1'b0;
      else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    hnm_out_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        $error("unexpected transfer %h", out_data);
        errors++;
      end else begin
        exp_px = expected_px.pop_front();
        if (out_data.normal_red !== exp_px.normal_red) begin
          $error("normal_red exp %0d got %0d", exp_px.normal_red, out_data.normal_red);
          errors++;
        end
        if (out_data.normal_green !== exp_px.normal_green) begin
          $error("normal_green exp %0d got %0d", exp_px.normal_green, out_data.normal_green);
          errors++;
        end
        if (out_data.normal_blue !== exp_px.normal_blue) begin
          $error("normal_blue exp %0d got %0d", exp_px.normal_blue, out_data.normal_blue);
          errors++;
        end
        if (out_data.alpha_out !== exp_px.alpha_out) begin
          $error("alpha_out exp %0d got %0d", exp_px.alpha_out, out_data.alpha_out);
          errors++;
        end
        if (out_data.coord_error !== exp_px.coord_error) begin
          $error("coord_error exp %0d got %0d", exp_px.coord_error, out_data.coord_error);
          errors++;
        end
      end
    end
  end

  initial begin
    img_w = 256; img_h = 256; scale_q88 = 16384;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    test_full_rows();
    drain();
    if (expected_px.size() != 0) errors++;
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule
